// ----- rtl/ssst_pkg.sv -----
// package for the sparse set table: sizes, opcodes, status codes and shared types
// depends on nothing; every other file but ssst_ram imports it

package ssst_pkg;

  localparam int SLOTS       = 1024;
  localparam int HANDLE_BITS = 32;
  localparam int HANDLE_W    = 32;
  localparam int STORE_W     = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int KEY_W       = SLOT_W;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int MAP_W       = SLOT_W + 1;
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;
  localparam int POS_W       = 10;
  localparam int CNT_OUT_W   = 10;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [ST_W-1:0] ST_DUP    = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] pos;
  } map_entry_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    map_entry_t        wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } map_req_t;

  typedef struct packed {
    logic               we;
    logic [SLOT_W-1:0]  waddr;
    logic [STORE_W-1:0] wdata;
    logic               re;
    logic [SLOT_W-1:0]  raddr;
  } dense_req_t;

  typedef struct packed {
    logic [POS_W-1:0]     position;
    logic [ST_W-1:0]      status;
    logic [CNT_OUT_W-1:0] count;
  } result_t;

endpackage

// ----- rtl/ssst_if.sv -----
// valid/ready channel interfaces for the sparse set table
// depends on ssst_pkg

interface ssst_in_if;
  import ssst_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, output opcode, output handle, input ready);
  modport sink (input valid, input opcode, input handle, output ready);
endinterface

interface ssst_out_if;
  import ssst_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [POS_W-1:0]     position;
  logic [ST_W-1:0]      status;
  logic [CNT_OUT_W-1:0] count;

  modport source (output valid, output position, output status, output count, input ready);
  modport sink (input valid, input position, input status, input count, output ready);
endinterface

// ----- rtl/ssst_ram.sv -----
// generic single write port ram with registered read
// no dependencies

module ssst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/ssst_ctrl.sv -----
// sequencer for the sparse set table: read, modify and write back of the key map
// and dense handle rams, clearing pass, result hold; depends on ssst_pkg

module ssst_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic [ssst_pkg::OP_W-1:0]    item_op,
  input  logic [ssst_pkg::HANDLE_W-1:0] item_handle,
  input  ssst_pkg::map_entry_t         map_rdata,
  input  logic [ssst_pkg::STORE_W-1:0] dense_rdata,
  output ssst_pkg::map_req_t           map_req,
  output ssst_pkg::dense_req_t         dense_req,
  output logic                         res_valid,
  input  logic                         res_ready,
  output ssst_pkg::result_t            res
);
  import ssst_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_REM1 = 3'd2;
  localparam logic [2:0] S_REM2 = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_HOLD = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [STORE_W-1:0] hdl_r, hdl_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [SLOT_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic               clr_resp_r, clr_resp_nxt;
  result_t            hold_r, hold_nxt;

  logic               accept;
  logic [STORE_W-1:0] in_hdl;
  logic [KEY_W-1:0]   in_key;
  logic               in_key_ok;
  logic [CNT_W-1:0]   cnt_dec;
  logic [CNT_W-1:0]   cnt_inc;
  logic [SLOT_W-1:0]  last_idx;

  function automatic result_t make_result(input logic [SLOT_W-1:0] pos,
                                          input logic [ST_W-1:0] st,
                                          input logic [CNT_W-1:0] cnt);
    result_t r;
    r.position = POS_W'(pos);
    r.status   = st;
    r.count    = CNT_OUT_W'(cnt);
    return r;
  endfunction

  assign item_ready = (state_r == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign in_hdl     = item_handle[STORE_W-1:0];
  assign in_key     = in_hdl[KEY_W-1:0];
  assign in_key_ok  = (in_key < KEY_W'(SLOTS - 1));
  assign cnt_dec    = count_r - CNT_W'(1);
  assign cnt_inc    = count_r + CNT_W'(1);
  assign last_idx   = cnt_dec[SLOT_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    hdl_nxt      = hdl_r;
    count_nxt    = count_r;
    slot_nxt     = slot_r;
    clr_idx_nxt  = clr_idx_r;
    clr_resp_nxt = clr_resp_r;
    hold_nxt     = hold_r;
    map_req      = '0;
    dense_req    = '0;
    res_valid    = 1'b0;
    res          = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt  = item_op;
          key_nxt = in_key;
          hdl_nxt = in_hdl;
          if (item_op == OP_CLEAR) begin
            count_nxt    = '0;
            clr_idx_nxt  = '0;
            clr_resp_nxt = 1'b1;
            state_nxt    = S_CLR;
          end else if (!in_key_ok) begin
            res_valid = 1'b1;
            res       = make_result('0, ST_ABSENT, count_r);
          end else begin
            map_req.re    = 1'b1;
            map_req.raddr = in_key;
            if (item_op == OP_REMOVE) begin
              dense_req.re    = 1'b1;
              dense_req.raddr = last_idx;
              state_nxt       = S_REM1;
            end else begin
              state_nxt = S_LOOK;
            end
          end
        end
      end
      S_LOOK: begin
        res_valid = 1'b1;
        state_nxt = S_IDLE;
        if (op_r == OP_ADD) begin
          if (map_rdata.valid) begin
            res = make_result(map_rdata.pos, ST_DUP, count_r);
          end else if (count_r >= CNT_W'(SLOTS)) begin
            res = make_result('0, ST_FULL, count_r);
          end else begin
            dense_req.we        = 1'b1;
            dense_req.waddr     = count_r[SLOT_W-1:0];
            dense_req.wdata     = hdl_r;
            map_req.we          = 1'b1;
            map_req.waddr       = key_r;
            map_req.wdata.valid = 1'b1;
            map_req.wdata.pos   = count_r[SLOT_W-1:0];
            count_nxt           = cnt_inc;
            res = make_result(count_r[SLOT_W-1:0], ST_OK, cnt_inc);
          end
        end else begin
          if (map_rdata.valid) begin
            res = make_result(map_rdata.pos, ST_OK, count_r);
          end else begin
            res = make_result('0, ST_ABSENT, count_r);
          end
        end
      end
      S_REM1: begin
        if (!map_rdata.valid || (count_r == '0)) begin
          res_valid = 1'b1;
          res       = make_result('0, ST_ABSENT, count_r);
          state_nxt = S_IDLE;
        end else begin
          // last entry moves into the freed slot, its map entry follows it
          dense_req.we        = 1'b1;
          dense_req.waddr     = map_rdata.pos;
          dense_req.wdata     = dense_rdata;
          map_req.we          = 1'b1;
          map_req.waddr       = dense_rdata[KEY_W-1:0];
          map_req.wdata.valid = 1'b1;
          map_req.wdata.pos   = map_rdata.pos;
          slot_nxt            = map_rdata.pos;
          count_nxt           = cnt_dec;
          state_nxt           = S_REM2;
        end
      end
      S_REM2: begin
        // removed key invalidated after the move
        map_req.we    = 1'b1;
        map_req.waddr = key_r;
        res_valid     = 1'b1;
        res           = make_result(slot_r, ST_OK, count_r);
        state_nxt     = S_IDLE;
      end
      S_CLR: begin
        map_req.we    = 1'b1;
        map_req.waddr = clr_idx_r;
        clr_idx_nxt   = clr_idx_r + SLOT_W'(1);
        if (clr_idx_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
          if (clr_resp_r) begin
            res_valid = 1'b1;
            res       = make_result('0, ST_OK, count_r);
          end
        end
      end
      S_HOLD: begin
        res_valid = 1'b1;
        res       = hold_r;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (res_valid && !res_ready && (state_r != S_HOLD)) begin
      hold_nxt  = res;
      state_nxt = S_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      count_r    <= '0;
      clr_idx_r  <= '0;
      clr_resp_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      clr_idx_r  <= clr_idx_nxt;
      clr_resp_r <= clr_resp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    hdl_r  <= hdl_nxt;
    slot_r <= slot_nxt;
    hold_r <= hold_nxt;
  end

endmodule

// ----- rtl/sparse_set_swap_remove_table.sv -----
// top level of the sparse set table with swap remove: key map ram, dense handle ram,
// sequencer and output register; depends on ssst_pkg, ssst_if, ssst_ram, ssst_ctrl
// per item: add and find read the key map; remove reads map and last entry, then makes two
// map writes on the single map write port unless absent; clear sweeps all 1024 map entries
// results pass through the output register; the sequencer holds a result while it is full
// after reset a pass over all 1024 entries clears the key map while in_ch.ready stays low

module sparse_set_swap_remove_table (
  input  logic       clk,
  input  logic       rst_n,
  ssst_in_if.sink    in_ch,
  ssst_out_if.source out_ch
);
  import ssst_pkg::*;

  map_req_t           map_req;
  dense_req_t         dense_req;
  map_entry_t         map_rdata;
  logic [STORE_W-1:0] dense_rdata;
  logic               res_valid;
  logic               out_free;
  result_t            res;
  logic               out_valid_r;
  result_t            out_data_r;

  ssst_ram #(
    .WIDTH (MAP_W),
    .DEPTH (SLOTS)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_req.we),
    .waddr (map_req.waddr),
    .wdata (map_req.wdata),
    .re    (map_req.re),
    .raddr (map_req.raddr),
    .rdata (map_rdata)
  );

  ssst_ram #(
    .WIDTH (STORE_W),
    .DEPTH (SLOTS)
  ) u_dense_ram (
    .clk   (clk),
    .we    (dense_req.we),
    .waddr (dense_req.waddr),
    .wdata (dense_req.wdata),
    .re    (dense_req.re),
    .raddr (dense_req.raddr),
    .rdata (dense_rdata)
  );

  ssst_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (in_ch.valid),
    .item_ready  (in_ch.ready),
    .item_op     (in_ch.opcode),
    .item_handle (in_ch.handle),
    .map_rdata   (map_rdata),
    .dense_rdata (dense_rdata),
    .map_req     (map_req),
    .dense_req   (dense_req),
    .res_valid   (res_valid),
    .res_ready   (out_free),
    .res         (res)
  );

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.position = out_data_r.position;
  assign out_ch.status   = out_data_r.status;
  assign out_ch.count    = out_data_r.count;

endmodule

// ----- rtl/ssst_checker.sv -----
// port-level checks for the sparse set table and the bind that attaches them
// depends on ssst_pkg and sparse_set_swap_remove_table

module ssst_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [ssst_pkg::POS_W-1:0]      out_position,
  input logic [ssst_pkg::ST_W-1:0]       out_status,
  input logic [ssst_pkg::CNT_OUT_W-1:0]  out_count
);
  import ssst_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_position) && $stable(out_status) && $stable(out_count))
    else $error("stalled result changed");

  a_fail_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_ABSENT || out_status == ST_FULL) |-> out_position == '0)
    else $error("failed transaction carries a position");

  a_ok_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) |-> out_position <= out_count)
    else $error("position beyond entry count");

  a_dup_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_DUP) |-> out_count != '0)
    else $error("duplicate reported on empty table");

endmodule

bind sparse_set_swap_remove_table ssst_checker u_ssst_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_position (out_ch.position),
  .out_status   (out_ch.status),
  .out_count    (out_ch.count)
);
